// ===== sv/ucc_pkg.sv =====
// Shared types and constants for the UDP checksum checker.
`default_nettype none

package ucc_pkg;

    // Header byte positions within the datagram
    localparam logic [15:0] IDX_SRC_HI  = 16'd0;
    localparam logic [15:0] IDX_SRC_LO  = 16'd1;
    localparam logic [15:0] IDX_DST_HI  = 16'd2;
    localparam logic [15:0] IDX_DST_LO  = 16'd3;
    localparam logic [15:0] IDX_LEN_HI  = 16'd4;
    localparam logic [15:0] IDX_LEN_LO  = 16'd5;
    localparam logic [15:0] IDX_CSUM_HI = 16'd6;
    localparam logic [15:0] IDX_CSUM_LO = 16'd7;
    localparam logic [15:0] HDR_BYTES   = 16'd8;
    localparam logic [15:0] INDEX_MAX   = 16'hFFFF;

    localparam logic [15:0] UDP_PROTOCOL = 16'd17;

    // Status codes
    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // Job queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input request
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_ucc_req;

    // Result
    typedef struct packed {
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] udp_length;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
        logic [1:0]  status;
    } t_ucc_result;

    // One finished datagram handed from front to back
    typedef struct packed {
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] udp_length;
        logic [15:0] received_checksum;
        logic [15:0] data_sum;
        logic [15:0] pad_word;
        logic        short_dgram;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_ucc_job;

endpackage

`default_nettype wire

// ===== sv/udp_checksum_checker_unit.sv =====
// Top level of the UDP checksum checker: front end, job queue, back end.
// Throughput: one byte request per cycle; one result per cycle when i_stall is low.
// After the last byte is accepted, its job passes the queue write and the three register
//   stages of the back end (A, B, output) before the result is valid.
// Input stalls only while the four-entry job queue is full.
// Reset: synchronous, active low; clears byte count, sum, queue and valid bits.
`default_nettype none

module udp_checksum_checker_unit
    import ucc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_ucc_req    i_req,
    output logic             o_stall,
    output logic             o_valid,
    output t_ucc_result      o_result,
    input  wire logic        i_stall
);

    logic     w_push;
    logic     w_full;
    t_ucc_job w_push_job;
    logic     w_job_valid;
    t_ucc_job w_job;
    logic     w_pop;

    ucc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_req        (i_req),
        .o_stall      (o_stall),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    ucc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job)
    );

    ucc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall)
    );

    // Back end never pops an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_job_valid)
        else $error("job popped from empty queue");

    // A mismatch means a nonzero received checksum that differs from the computed one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_MISMATCH)) |->
        ((o_result.received_checksum != 16'h0000)
         && (o_result.received_checksum != o_result.computed_checksum)))
        else $error("mismatch status with agreeing checksums");

    // Status is never the unused code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.status == ST_MATCH) || (o_result.status == ST_MISMATCH)
                     || (o_result.status == ST_SHORT)))
        else $error("invalid status code");

endmodule

`default_nettype wire

// ===== sv/ucc_front.sv =====
// Front end: takes datagram bytes, captures header fields, keeps the data sum.
`default_nettype none

module ucc_front
    import ucc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_ucc_req i_req,
    output logic          o_stall,
    input  wire logic     i_queue_full,
    output logic          o_push,
    output t_ucc_job      o_job
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_src, n_src;
    logic [15:0] r_dst, n_dst;
    logic [15:0] r_len, n_len;
    logic [15:0] r_csum, n_csum;
    logic [15:0] w_counted;
    logic [7:0]  w_val;
    logic        w_accept;

    // Ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    assign o_stall  = i_queue_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = w_accept && i_req.last;

    // Update capture and sum for one byte
    always_comb begin
        n_byte_index = r_byte_index;
        n_sum        = r_sum;
        n_held       = r_held;
        n_src        = r_src;
        n_dst        = r_dst;
        n_len        = r_len;
        n_csum       = r_csum;
        w_val        = i_req.data_byte;
        w_counted    = INDEX_MAX;
        if (r_byte_index != INDEX_MAX) begin
            case (r_byte_index)
                IDX_SRC_HI:  n_src = {i_req.data_byte, 8'h00};
                IDX_SRC_LO:  n_src = r_src | {8'h00, i_req.data_byte};
                IDX_DST_HI:  n_dst = {i_req.data_byte, 8'h00};
                IDX_DST_LO:  n_dst = r_dst | {8'h00, i_req.data_byte};
                IDX_LEN_HI:  n_len = {i_req.data_byte, 8'h00};
                IDX_LEN_LO:  n_len = r_len | {8'h00, i_req.data_byte};
                IDX_CSUM_HI: begin
                    n_csum = {i_req.data_byte, 8'h00};
                    w_val  = 8'h00;
                end
                IDX_CSUM_LO: begin
                    n_csum = r_csum | {8'h00, i_req.data_byte};
                    w_val  = 8'h00;
                end
                default: ;
            endcase
            if (!r_byte_index[0]) begin
                n_held = w_val;
            end else begin
                n_sum = oc_add(r_sum, {r_held, w_val});
            end
            n_byte_index = r_byte_index + 16'd1;
            w_counted    = r_byte_index + 16'd1;
        end
    end

    // Build the job for the back end from the updated state
    always_comb begin
        o_job.source_port       = n_src;
        o_job.dest_port         = n_dst;
        o_job.udp_length        = n_len;
        o_job.received_checksum = n_csum;
        o_job.data_sum          = n_sum;
        o_job.pad_word          = w_counted[0] ? {n_held, 8'h00} : 16'h0000;
        o_job.short_dgram       = (w_counted < HDR_BYTES);
        o_job.src_ip            = i_req.src_ip;
        o_job.dst_ip            = i_req.dst_ip;
    end

    // Advance on each accepted byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_index <= '0;
            r_sum        <= '0;
            r_held       <= '0;
            r_src        <= '0;
            r_dst        <= '0;
            r_len        <= '0;
            r_csum       <= '0;
        end else if (w_accept) begin
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_held       <= n_held;
            r_src        <= n_src;
            r_dst        <= n_dst;
            r_len        <= n_len;
            r_csum       <= n_csum;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ucc_queue.sv =====
// Small job queue between front and back ends.
`default_nettype none

module ucc_queue
    import ucc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_ucc_job i_job,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_ucc_job      o_job
);

    t_ucc_job            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Write storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ucc_back.sv =====
// Back end: adds the pseudo-header, folds, compares and holds the result.
`default_nettype none

module ucc_back
    import ucc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_job_valid,
    input  wire t_ucc_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    output t_ucc_result   o_result,
    input  wire logic     i_stall
);

    logic        w_advance;

    // Stage A
    logic        r_a_valid;
    t_ucc_job    r_a_job;
    logic [17:0] r_a_sum_lo, r_a_sum_hi;
    logic [17:0] n_a_sum_lo, n_a_sum_hi;

    // Stage B
    logic        r_b_valid;
    t_ucc_job    r_b_job;
    logic [15:0] r_b_computed, n_b_computed;
    logic [18:0] w_total;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;

    // Output stage
    logic        r_out_valid;
    t_ucc_result r_out, n_out;
    logic        w_match;

    assign w_advance = !r_out_valid || !i_stall;
    assign o_pop     = w_advance && i_job_valid;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // Sum the eight words in two groups of four
    always_comb begin
        n_a_sum_lo = {2'b00, i_job.data_sum} + {2'b00, i_job.pad_word}
                   + {2'b00, i_job.src_ip[31:16]} + {2'b00, i_job.src_ip[15:0]};
        n_a_sum_hi = {2'b00, i_job.dst_ip[31:16]} + {2'b00, i_job.dst_ip[15:0]}
                   + {2'b00, UDP_PROTOCOL} + {2'b00, i_job.udp_length};
    end

    // Combine, fold carries back in twice, invert
    always_comb begin
        w_total      = {1'b0, r_a_sum_lo} + {1'b0, r_a_sum_hi};
        w_fold1      = {1'b0, w_total[15:0]} + {14'd0, w_total[18:16]};
        w_fold2      = w_fold1[15:0] + {15'd0, w_fold1[16]};
        n_b_computed = ~w_fold2;
    end

    // Compare and pick the status
    always_comb begin
        w_match = (r_b_job.received_checksum == 16'h0000)
               || (r_b_job.received_checksum == r_b_computed)
               || ((r_b_computed == 16'h0000) && (r_b_job.received_checksum == 16'hFFFF));
        n_out.source_port       = r_b_job.source_port;
        n_out.dest_port         = r_b_job.dest_port;
        n_out.udp_length        = r_b_job.udp_length;
        n_out.received_checksum = r_b_job.received_checksum;
        n_out.computed_checksum = r_b_computed;
        if (r_b_job.short_dgram) begin
            n_out.status = ST_SHORT;
        end else if (w_match) begin
            n_out.status = ST_MATCH;
        end else begin
            n_out.status = ST_MISMATCH;
        end
    end

    // Advance payload; hold everything while the output is stalled
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_a_job      <= i_job;
            r_a_sum_lo   <= n_a_sum_lo;
            r_a_sum_hi   <= n_a_sum_hi;
            r_b_job      <= r_a_job;
            r_b_computed <= n_b_computed;
            r_out        <= n_out;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_a_valid   <= i_job_valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_udp_checksum_checker_unit.sv =====
// Testbench for the UDP checksum checker: byte stimulus, result prediction and checking.

module tb_udp_checksum_checker_unit
    import ucc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 20;
    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam int          TAIL_CYCLES    = 8;

    typedef logic [7:0] t_byte_queue [$];

    // Checksum field treatment for generated datagrams
    typedef enum int {
        CK_GOOD,
        CK_NONE,
        CK_BAD,
        CK_ZERO_SUM,
        CK_NOISE
    } t_csum_kind;

    // Predict results from accepted byte requests and check the block's output against them
    class checksum_scoreboard;
        logic [15:0]  byte_count;
        logic [15:0]  word_sum;
        logic [7:0]   high_byte;
        logic [15:0]  source_port;
        logic [15:0]  dest_port;
        logic [15:0]  length_field;
        logic [15:0]  csum_field;
        t_ucc_result  expected_q[$];
        int unsigned  mismatches;
        int unsigned  results_seen;

        function new();
            clear();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void clear();
            byte_count   = '0;
            word_sum     = '0;
            high_byte    = '0;
            source_port  = '0;
            dest_port    = '0;
            length_field = '0;
            csum_field   = '0;
        endfunction

        // Add a word with end-around carry
        function logic [15:0] fold_add(logic [15:0] acc, logic [15:0] word);
            logic [16:0] t;
            t = {1'b0, acc} + {1'b0, word};
            return t[15:0] + {15'd0, t[16]};
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(t_ucc_req req);
            logic [7:0]  low;
            logic [15:0] counted;
            logic [15:0] acc;
            logic [15:0] computed;
            logic        match;
            t_ucc_result r;
            if (byte_count != INDEX_MAX) begin
                low = req.data_byte;
                // Capture header fields; the checksum field sums as zero
                case (byte_count)
                    IDX_SRC_HI:  source_port = {req.data_byte, 8'h00};
                    IDX_SRC_LO:  source_port = source_port | {8'h00, req.data_byte};
                    IDX_DST_HI:  dest_port = {req.data_byte, 8'h00};
                    IDX_DST_LO:  dest_port = dest_port | {8'h00, req.data_byte};
                    IDX_LEN_HI:  length_field = {req.data_byte, 8'h00};
                    IDX_LEN_LO:  length_field = length_field | {8'h00, req.data_byte};
                    IDX_CSUM_HI: begin
                        csum_field = {req.data_byte, 8'h00};
                        low = 8'h00;
                    end
                    IDX_CSUM_LO: begin
                        csum_field = csum_field | {8'h00, req.data_byte};
                        low = 8'h00;
                    end
                    default: ;
                endcase
                if (byte_count[0] == 1'b0) begin
                    high_byte = low;
                end else begin
                    word_sum = fold_add(word_sum, {high_byte, low});
                end
                byte_count = byte_count + 16'd1;
                counted = byte_count;
            end else begin
                // Oversize: drop the byte, count stays saturated
                counted = INDEX_MAX;
            end
            if (!req.last) return;

            // Pad an odd tail, then fold in the pseudo-header
            acc = word_sum;
            if (counted[0]) acc = fold_add(acc, {high_byte, 8'h00});
            acc = fold_add(acc, req.src_ip[31:16]);
            acc = fold_add(acc, req.src_ip[15:0]);
            acc = fold_add(acc, req.dst_ip[31:16]);
            acc = fold_add(acc, req.dst_ip[15:0]);
            acc = fold_add(acc, UDP_PROTOCOL);
            acc = fold_add(acc, length_field);
            computed = ~acc;

            match = (csum_field == 16'h0000) || (csum_field == computed) ||
                    (computed == 16'h0000 && csum_field == 16'hFFFF);
            r.source_port       = source_port;
            r.dest_port         = dest_port;
            r.udp_length        = length_field;
            r.received_checksum = csum_field;
            r.computed_checksum = computed;
            if (counted < HDR_BYTES) r.status = ST_SHORT;
            else if (match)          r.status = ST_MATCH;
            else                     r.status = ST_MISMATCH;
            expected_q.push_back(r);
            clear();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %h, got %h",
                             results_seen, name, want, got);
            end
        endfunction

        function void check_result(t_ucc_result got);
            t_ucc_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: unexpected result %h", results_seen, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("source_port", want.source_port, got.source_port);
            compare_field("dest_port", want.dest_port, got.dest_port);
            compare_field("udp_length", want.udp_length, got.udp_length);
            compare_field("received_checksum", want.received_checksum,
                          got.received_checksum);
            compare_field("computed_checksum", want.computed_checksum,
                          got.computed_checksum);
            compare_field("status", {14'd0, want.status}, {14'd0, got.status});
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_ucc_req    i_req   = '0;
    logic        o_stall;
    logic        o_valid;
    t_ucc_result o_result;
    logic        i_stall = 1'b0;

    checksum_scoreboard sb = new();
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned sent_bytes = 0;
    int unsigned sent_dgrams = 0;

    udp_checksum_checker_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_req    (i_req),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check accepted results, then pick the next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_result);
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Hold off the sender, present one request and wait for its acceptance
    task automatic send_request(input t_ucc_req req);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(req);
        sent_bytes++;
    endtask

    task automatic send_datagram(input t_byte_queue data, input logic [31:0] sip,
                                 input logic [31:0] dip, input bit wobble_ip);
        t_ucc_req req;
        foreach (data[i]) begin
            req.data_byte = data[i];
            req.last      = (i == data.size() - 1);
            req.src_ip    = wobble_ip ? $urandom() : sip;
            req.dst_ip    = wobble_ip ? $urandom() : dip;
            send_request(req);
        end
        sent_dgrams++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Checksum the block should compute for a datagram, from a scratch predictor
    function automatic logic [15:0] datagram_checksum(t_byte_queue data, logic [31:0] sip,
                                                      logic [31:0] dip);
        checksum_scoreboard calc;
        t_ucc_req req;
        calc = new();
        foreach (data[i]) begin
            req.data_byte = data[i];
            req.last      = (i == data.size() - 1);
            req.src_ip    = sip;
            req.dst_ip    = dip;
            calc.note_request(req);
        end
        return calc.expected_q[0].computed_checksum;
    endfunction

    // Build random content with a chosen length field and checksum field
    function automatic void make_datagram(input int n, input t_csum_kind kind,
                                          input logic [31:0] sip, input logic [31:0] dip,
                                          input bit true_len, output t_byte_queue data);
        logic [15:0] csum;
        logic [15:0] field;
        data.delete();
        for (int i = 0; i < n; i++) data.push_back(8'($urandom_range(255)));
        if (kind == CK_NOISE) return;
        if (n >= 6 && true_len) begin
            data[4] = n[15:8];
            data[5] = n[7:0];
        end
        if (n < 8) return;
        data[6] = 8'h00;
        data[7] = 8'h00;
        // Steer the sum to all ones so the computed checksum comes out zero
        if (kind == CK_ZERO_SUM && n >= 10) begin
            data[8] = 8'h00;
            data[9] = 8'h00;
            csum = datagram_checksum(data, sip, dip);
            data[8] = csum[15:8];
            data[9] = csum[7:0];
        end
        csum = datagram_checksum(data, sip, dip);
        case (kind)
            CK_NONE:     field = 16'h0000;
            CK_BAD:      field = csum ^ (16'h0001 << $urandom_range(15));
            CK_ZERO_SUM: field = (csum == 16'h0000) ? 16'hFFFF : csum;
            default:     field = csum;
        endcase
        data[6] = field[15:8];
        data[7] = field[7:0];
    endfunction

    function automatic int pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return $urandom_range(7, 1);
        if (r < 85) return $urandom_range(24, 8);
        return $urandom_range(64, 25);
    endfunction

    function automatic t_csum_kind pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return CK_GOOD;
        if (r < 60) return CK_NONE;
        if (r < 75) return CK_BAD;
        if (r < 85) return CK_ZERO_SUM;
        return CK_NOISE;
    endfunction

    // Give up on a hung run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_udp_checksum_checker_unit: done, errors");
        $finish;
    end

    initial begin
        t_byte_queue data;
        t_csum_kind  kind;
        logic [31:0] sip;
        logic [31:0] dip;
        int unsigned phase_bytes;
        int unsigned phase_dgrams;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte datagram of all ones with all-ones addresses
        data = '{8'hFF};
        send_datagram(data, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        // Short datagram of seven bytes, zero addresses
        make_datagram(7, CK_GOOD, 32'h0, 32'h0, 1'b1, data);
        send_datagram(data, 32'h0, 32'h0, 1'b0);
        // Header only, extreme ports, no checksum sent
        data = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00};
        send_datagram(data, $urandom(), $urandom(), 1'b0);
        // Computed checksum of zero, transmitted as all ones
        sip = $urandom();
        dip = $urandom();
        make_datagram(10, CK_ZERO_SUM, sip, dip, 1'b1, data);
        send_datagram(data, sip, dip, 1'b0);
        drain_results();

        // Random phases: none, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++) begin
            idle_pct  = (p == 1) ? 62 : (p == 3) ? 18 : 0;
            stall_pct = (p == 2) ? 62 : (p == 3) ? 18 : 0;
            phase_bytes  = 0;
            phase_dgrams = 0;
            while (phase_bytes < 140 || phase_dgrams < 6) begin
                sip  = $urandom();
                dip  = $urandom();
                kind = pick_kind();
                make_datagram(pick_length(), kind, sip, dip, $urandom_range(99) < 85, data);
                send_datagram(data, sip, dip, kind == CK_NOISE);
                phase_bytes += data.size();
                phase_dgrams++;
                if ($urandom_range(11) == 0) drain_results();
            end
            drain_results();
        end

        stall_pct = 0;
        if (sb.pending() != 0) sb.mismatches++;
        $display("Sent %0d datagrams (%0d bytes) over four idle/stall phases,",
                 sent_dgrams, sent_bytes);
        $display("including short, bad, absent and zero checksums; %0d results checked.",
                 sb.results_seen);
        if (sb.mismatches == 0) begin
            $display("tb_udp_checksum_checker_unit: done, clean");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("tb_udp_checksum_checker_unit: done, errors");
        end
        $finish;
    end

endmodule
